@@ src/ctbp_pkg.sv @@
// Shared constants and types for the code table bit packer.
package ctbp_pkg;

   localparam int MAX_CODE_LEN     = 32;
   localparam int MAX_SYMBOL_WIDTH = 16;
   localparam int LEN_FIELD_BITS   = 8;

   localparam int SYM_W    = 16;
   localparam int LEN_W    = 6;
   localparam int CODE_W   = 32;
   localparam int SW_W     = 5;
   localparam int ACC_W    = 64;
   localparam int TOTAL_W  = 7;
   localparam int CARRY_W  = 7;
   localparam int NBYTES_W = 3;
   localparam int TAIL_W   = 3;
   localparam int BYTE_W   = 8;
   localparam int ADDR_W   = 4;
   localparam int DATA_W   = 32;

   localparam logic [1:0] REG_SYMBOL_WIDTH = 2'd0;
   localparam logic [1:0] REG_KEY_BYTE     = 2'd1;
   localparam logic [1:0] REG_CHECK_SEED   = 2'd2;

   localparam logic [SW_W-1:0]   SYMBOL_WIDTH_RESET = 5'd8;
   localparam logic [BYTE_W-1:0] KEY_BYTE_RESET     = 8'd0;
   localparam logic [BYTE_W-1:0] CHECK_SEED_RESET   = 8'd0;

   localparam logic KIND_BYTE = 1'b0;
   localparam logic KIND_TAIL = 1'b1;

   typedef struct packed {
      logic [SW_W-1:0]   symbol_width;
      logic [BYTE_W-1:0] key_byte;
      logic [BYTE_W-1:0] check_seed;
   } cfg_type;

   typedef struct packed {
      logic [ACC_W-1:0]    bits;
      logic [NBYTES_W-1:0] nbytes;
      logic                tail;
      logic [TAIL_W-1:0]   tail_count;
      logic                first;
   } pack_type;

endpackage

@@ src/ctbp_csr.sv @@
// Configuration registers behind the APB-style port.
module ctbp_csr import ctbp_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [ADDR_W-1:0] csr_paddr,
   input  logic [DATA_W-1:0] csr_pwdata,
   output logic [DATA_W-1:0] csr_prdata,
   output logic              csr_pready,
   output cfg_type           cfg
);

   cfg_type    cfg_ff;
   cfg_type    cfg_in;
   logic       wr_en;
   logic [1:0] reg_idx;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign reg_idx    = csr_paddr[3:2];
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_idx)
            REG_SYMBOL_WIDTH: cfg_in.symbol_width = csr_pwdata[SW_W-1:0];
            REG_KEY_BYTE:     cfg_in.key_byte     = csr_pwdata[BYTE_W-1:0];
            REG_CHECK_SEED:   cfg_in.check_seed   = csr_pwdata[BYTE_W-1:0];
            default:          cfg_in              = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         REG_SYMBOL_WIDTH: csr_prdata = {{(DATA_W-SW_W){1'b0}}, cfg_ff.symbol_width};
         REG_KEY_BYTE:     csr_prdata = {{(DATA_W-BYTE_W){1'b0}}, cfg_ff.key_byte};
         REG_CHECK_SEED:   csr_prdata = {{(DATA_W-BYTE_W){1'b0}}, cfg_ff.check_seed};
         default:          csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.symbol_width <= SYMBOL_WIDTH_RESET;
         cfg_ff.key_byte     <= KEY_BYTE_RESET;
         cfg_ff.check_seed   <= CHECK_SEED_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

@@ src/ctbp_packer.sv @@
// Input register and bit packer: joins carry bits and the item's fields.
module ctbp_packer import ctbp_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  cfg_type           cfg,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [SYM_W-1:0]  req_symbol,
   input  logic [LEN_W-1:0]  req_code_length,
   input  logic [CODE_W-1:0] req_code_bits,
   input  logic              req_is_first,
   input  logic              req_is_last,
   input  logic              pk_ready,
   output logic              pk_valid,
   output pack_type          pk
);

   logic              in_valid_ff, in_valid_in;
   logic [SYM_W-1:0]  in_symbol_ff;
   logic [LEN_W-1:0]  in_len_ff;
   logic [CODE_W-1:0] in_code_ff;
   logic              in_first_ff;
   logic              in_last_ff;
   logic [CARRY_W-1:0] carry_ff, carry_in;
   logic [TAIL_W-1:0]  carry_cnt_ff, carry_cnt_in;

   logic               accept;
   logic               load;
   logic [SW_W-1:0]    sw;
   logic [LEN_W-1:0]   len;
   logic [CARRY_W-1:0] cb;
   logic [TAIL_W-1:0]  cc;
   logic [SYM_W-1:0]   sym_m;
   logic [CODE_W-1:0]  code_m;
   logic [ACC_W-1:0]   v_sym;
   logic [ACC_W-1:0]   v_len;
   logic [ACC_W-1:0]   v_all;
   logic [TOTAL_W-1:0] total;
   logic [CARRY_W-1:0] carry_new;

   assign load      = pk_valid && pk_ready;
   assign req_stall = in_valid_ff && !load;
   assign accept    = req_valid && !req_stall;
   assign pk_valid  = in_valid_ff;

   always_comb begin
      if (cfg.symbol_width == '0) begin
         sw = SW_W'(1);
      end else if (cfg.symbol_width > SW_W'(MAX_SYMBOL_WIDTH)) begin
         sw = SW_W'(MAX_SYMBOL_WIDTH);
      end else begin
         sw = cfg.symbol_width;
      end
      len = (in_len_ff > LEN_W'(MAX_CODE_LEN)) ? LEN_W'(MAX_CODE_LEN) : in_len_ff;
      cb  = in_first_ff ? '0 : carry_ff;
      cc  = in_first_ff ? '0 : carry_cnt_ff;

      sym_m  = in_symbol_ff & ({SYM_W{1'b1}} >> (SW_W'(SYM_W) - sw));
      code_m = in_code_ff & ({CODE_W{1'b1}} >> (LEN_W'(CODE_W) - len));

      v_sym = ({{(ACC_W-CARRY_W){1'b0}}, cb} << sw) | {{(ACC_W-SYM_W){1'b0}}, sym_m};
      v_len = (v_sym << LEN_FIELD_BITS)
            | {{(ACC_W-LEN_W){1'b0}}, len};
      v_all = (v_len << len) | {{(ACC_W-CODE_W){1'b0}}, code_m};

      total = TOTAL_W'(cc) + TOTAL_W'(sw) + TOTAL_W'(LEN_FIELD_BITS) + TOTAL_W'(len);

      pk.bits       = v_all << (TOTAL_W'(ACC_W) - total);
      pk.nbytes     = total[NBYTES_W+2:3];
      pk.tail       = in_last_ff;
      pk.tail_count = total[2:0];
      pk.first      = in_first_ff;

      carry_new = v_all[CARRY_W-1:0] & ({CARRY_W{1'b1}} >> (TAIL_W'(CARRY_W) - total[2:0]));
   end

   always_comb begin
      in_valid_in  = in_valid_ff;
      carry_in     = carry_ff;
      carry_cnt_in = carry_cnt_ff;
      if (accept) begin
         in_valid_in = 1'b1;
      end else if (load) begin
         in_valid_in = 1'b0;
      end
      if (load) begin
         carry_in     = in_last_ff ? '0 : carry_new;
         carry_cnt_in = in_last_ff ? '0 : total[2:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         carry_ff     <= '0;
         carry_cnt_ff <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         carry_ff     <= carry_in;
         carry_cnt_ff <= carry_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_symbol_ff <= req_symbol;
         in_len_ff    <= req_code_length;
         in_code_ff   <= req_code_bits;
         in_first_ff  <= req_is_first;
         in_last_ff   <= req_is_last;
      end
   end

   a_last_clears_carry: assert property (@(posedge clock) disable iff (reset)
      load && in_last_ff |=> carry_cnt_ff == '0 && carry_ff == '0)
      else $error("carry not cleared after last entry");

   a_held_until_load: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !load |=> in_valid_ff && $stable(in_code_ff))
      else $error("input register dropped an item");

endmodule

@@ src/ctbp_emitter.sv @@
// Byte serializer, running check and result register.
module ctbp_emitter import ctbp_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  cfg_type           cfg,
   input  logic              pk_valid,
   output logic              pk_ready,
   input  pack_type          pk,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic              rsp_result_kind,
   output logic [BYTE_W-1:0] rsp_out_byte,
   output logic [TAIL_W-1:0] rsp_tail_count,
   output logic [BYTE_W-1:0] rsp_check_value,
   output logic              rsp_last_result
);

   logic [ACC_W-1:0]    buf_ff, buf_in;
   logic [NBYTES_W-1:0] nbytes_ff, nbytes_in;
   logic                tail_ff, tail_in;
   logic [TAIL_W-1:0]   tcnt_ff, tcnt_in;
   logic [BYTE_W-1:0]   check_ff, check_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_kind_ff;
   logic [BYTE_W-1:0]   rsp_byte_ff;
   logic [TAIL_W-1:0]   rsp_tcnt_ff;
   logic [BYTE_W-1:0]   rsp_check_ff;
   logic                rsp_last_ff;

   logic                busy;
   logic                out_free;
   logic                fire;
   logic                is_byte;
   logic                final_res;
   logic                load;
   logic [BYTE_W-1:0]   plain;
   logic [BYTE_W-1:0]   check_step;

   assign busy       = (nbytes_ff != '0) || tail_ff;
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign fire       = busy && out_free;
   assign is_byte    = nbytes_ff != '0;
   assign final_res  = is_byte ? (nbytes_ff == NBYTES_W'(1) && !tail_ff) : 1'b1;
   assign pk_ready   = !busy || (fire && final_res);
   assign load       = pk_valid && pk_ready;
   assign plain      = buf_ff[ACC_W-1 -: BYTE_W];
   assign check_step = (fire && is_byte) ? (check_ff ^ plain) : check_ff;

   always_comb begin
      buf_in    = buf_ff;
      nbytes_in = nbytes_ff;
      tail_in   = tail_ff;
      tcnt_in   = tcnt_ff;
      check_in  = check_step;
      if (fire) begin
         if (is_byte) begin
            buf_in    = buf_ff << BYTE_W;
            nbytes_in = nbytes_ff - NBYTES_W'(1);
         end else begin
            tail_in = 1'b0;
         end
      end
      if (load) begin
         buf_in    = pk.bits;
         nbytes_in = pk.nbytes;
         tail_in   = pk.tail;
         tcnt_in   = pk.tail_count;
         if (pk.first) begin
            check_in = cfg.check_seed;
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (fire) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         nbytes_ff    <= '0;
         tail_ff      <= 1'b0;
         check_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         nbytes_ff    <= nbytes_in;
         tail_ff      <= tail_in;
         check_ff     <= check_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      buf_ff  <= buf_in;
      tcnt_ff <= tcnt_in;
      if (fire) begin
         rsp_kind_ff  <= is_byte ? KIND_BYTE : KIND_TAIL;
         rsp_byte_ff  <= is_byte ? (plain ^ cfg.key_byte) : plain;
         rsp_tcnt_ff  <= is_byte ? '0 : tcnt_ff;
         rsp_check_ff <= check_step;
         rsp_last_ff  <= final_res;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_result_kind = rsp_kind_ff;
   assign rsp_out_byte    = rsp_byte_ff;
   assign rsp_tail_count  = rsp_tcnt_ff;
   assign rsp_check_value = rsp_check_ff;
   assign rsp_last_result = rsp_last_ff;

   a_tail_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_kind_ff == KIND_TAIL |-> rsp_last_ff)
      else $error("tail result not marked last");

   a_byte_no_tail_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_kind_ff == KIND_BYTE |-> rsp_tcnt_ff == '0)
      else $error("byte result carries a tail count");

   a_check_follows_byte: assert property (@(posedge clock) disable iff (reset)
      fire && is_byte && !(load && pk.first) |=>
         check_ff == ($past(check_ff) ^ $past(buf_ff[ACC_W-1 -: BYTE_W])))
      else $error("running check out of step");

endmodule

@@ src/code_table_bit_packer.sv @@
// Top level of the code table bit packer.
// Each accepted item (one code table entry) is taken into an input register
// and packed there with the leftover bits of the previous entry; the packed
// bits then move to a byte serializer that sends one result per cycle while
// the result channel does not stall. An entry yields between one and eight
// results (at least one byte, up to seven bytes and a tail when it is marked
// last), so the result channel sets the sustained rate. When the serializer is
// free, the first result of an entry passes the input register, the serializer
// buffer and the result register. Configuration registers: symbol_width at 0x0,
// key_byte at 0x4, check_seed at 0x8; write them only while the block is idle.
module code_table_bit_packer import ctbp_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [ADDR_W-1:0] csr_paddr,
   input  logic [DATA_W-1:0] csr_pwdata,
   output logic [DATA_W-1:0] csr_prdata,
   output logic              csr_pready,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [SYM_W-1:0]  req_symbol,
   input  logic [LEN_W-1:0]  req_code_length,
   input  logic [CODE_W-1:0] req_code_bits,
   input  logic              req_is_first,
   input  logic              req_is_last,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic              rsp_result_kind,
   output logic [BYTE_W-1:0] rsp_out_byte,
   output logic [TAIL_W-1:0] rsp_tail_count,
   output logic [BYTE_W-1:0] rsp_check_value,
   output logic              rsp_last_result
);

   cfg_type  cfg;
   pack_type pk;
   logic     pk_valid;
   logic     pk_ready;

   ctbp_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   ctbp_packer u_packer (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_symbol      (req_symbol),
      .req_code_length (req_code_length),
      .req_code_bits   (req_code_bits),
      .req_is_first    (req_is_first),
      .req_is_last     (req_is_last),
      .pk_ready        (pk_ready),
      .pk_valid        (pk_valid),
      .pk              (pk)
   );

   ctbp_emitter u_emitter (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg),
      .pk_valid        (pk_valid),
      .pk_ready        (pk_ready),
      .pk              (pk),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_result_kind (rsp_result_kind),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_tail_count  (rsp_tail_count),
      .rsp_check_value (rsp_check_value),
      .rsp_last_result (rsp_last_result)
   );

endmodule
